// File: rtl/set_assoc_cache_controller_unit_assert.svh
// assertion macros for the set-associative cache controller
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef SET_ASSOC_CACHE_CONTROLLER_UNIT_ASSERT_SVH
`define SET_ASSOC_CACHE_CONTROLLER_UNIT_ASSERT_SVH

// condition must never hold at a clock edge outside reset
`define SACC_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// antecedent implies consequent at the next clock edge
`define SACC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/sacc_pkg.sv
// shared types and constants of the set-associative cache controller
// no dependencies
package sacc_pkg;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_FLUSH = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		CFG_WRITE_BACK     = 3'd0,
		CFG_RANDOM_REPLACE = 3'd1,
		CFG_OFFSET_BITS    = 3'd2,
		CFG_SET_BITS       = 3'd3,
		CFG_WAY_BITS       = 3'd4,
		CFG_RANDOM_SEED    = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_TREAD,
		ST_TWAIT,
		ST_UPDATE,
		ST_FLUSH,
		ST_FINISH
	} state_t;

	// one line of tag storage
	typedef struct packed {
		logic        valid;
		logic        dirty;
		logic [3:0]  rank;
		logic [31:0] tag;
	} line_t;

	localparam int unsigned LINE_BITS = 38;
	localparam logic [3:0]  RANK_MAX = 4'd15;
	localparam logic [15:0] SEED_DEFAULT = 16'd44257;
	localparam logic [15:0] LFSR_MASK = 16'hB400;

endpackage

// File: rtl/sacc_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module sacc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/set_assoc_cache_controller_unit.sv
// set-associative tag cache controller: read, write and flush commands
// read and write scan the ways of the set, read the target way and update the ranks;
// a write miss with write-through on ends after the tag scan
// flush with write-back on sweeps all lines, other commands finish directly
// one item at a time; the single ram port pair sets the per-way cost
// reset: asynchronous active low, then a clearing pass over all MAX_LINES entries
// of the tag ram during which no item is taken (config writes are)
// depends on sacc_pkg, sacc_ram and the assertion header
`include "set_assoc_cache_controller_unit_assert.svh"

module set_assoc_cache_controller_unit #(
	parameter int MAX_LINES    = 1024,
	parameter int MAX_WAYS     = 16,
	parameter int COUNTER_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  command,
	input  logic [31:0] address,
	// result channel
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        hit,
	output logic        line_fetched,
	output logic [10:0] memory_writes,
	output logic [47:0] total_reads,
	output logic [47:0] total_writes,
	output logic [47:0] read_hits,
	output logic [47:0] write_hits,
	output logic [47:0] memory_reads_total,
	output logic [47:0] memory_writes_total,
	// configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// geometry derived from the parameters
	localparam int LINE_W = MAX_LINES > 1 ? $clog2(MAX_LINES) : 1;
	localparam int CNT_W  = $clog2(MAX_LINES + 1);
	localparam int LINE_LOG = $clog2(MAX_LINES + 1) - 1;
	localparam int WAY_LOG  = $clog2(MAX_WAYS + 1) - 1;
	localparam logic [4:0] LINE_LOG_C = 5'(LINE_LOG);
	localparam logic [4:0] WAY_LOG_C  = 5'(WAY_LOG);
	localparam logic [CNT_W-1:0] LINES_C = CNT_W'(MAX_LINES);
	localparam int SW = COUNTER_BITS + CNT_W + 1;
	localparam logic [COUNTER_BITS-1:0] CMAX = '1;

	// configuration registers
	logic        write_back_q;
	logic        random_replace_q;
	logic [3:0]  offset_bits_q;
	logic [3:0]  set_bits_q;
	logic [2:0]  way_bits_q;
	logic [15:0] lfsr_q;

	sacc_pkg::state_t state_q, state_nx;

	// per-item registers
	sacc_pkg::cmd_t    cmd_q;
	logic [31:0]       tag_q;
	logic [LINE_W-1:0] base_q;
	logic [CNT_W-1:0]  len_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              found_q, inv_q, alloc_q, fetch_q;
	logic [LINE_W-1:0] hw_q, iw_q, best_q, tw_q;
	logic [3:0]        best_rank_q;
	logic              old_valid_q;
	logic [3:0]        old_rank_q;
	logic [CNT_W-1:0]  mw_q;

	// ram read pipeline
	logic              rv_s1;
	logic [LINE_W-1:0] rj_s1;

	logic [COUNTER_BITS-1:0] ctr_q [6];

	logic              rsp_valid_q;
	logic              hit_q, fetched_q;
	logic [10:0]       mwr_q;

	// ram ports
	logic              ram_we;
	logic [LINE_W-1:0] ram_waddr, ram_raddr;
	sacc_pkg::line_t   ram_wdata, rd;
	logic [sacc_pkg::LINE_BITS-1:0] ram_rdata;

	assign rd = sacc_pkg::line_t'(ram_rdata);

	sacc_ram #(
		.WIDTH(sacc_pkg::LINE_BITS),
		.DEPTH(MAX_LINES)
	) u_tag_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// sweep control shared by scan, update and flush
	logic sweep_st, issue, sweep_done;
	assign sweep_st   = state_q == sacc_pkg::ST_SCAN || state_q == sacc_pkg::ST_UPDATE ||
	                    state_q == sacc_pkg::ST_FLUSH;
	assign issue      = cnt_q < len_q;
	assign sweep_done = !issue && !rv_s1;

	// handshakes
	logic req_acc, fin_go;
	assign req_stall = state_q != sacc_pkg::ST_IDLE;
	assign req_acc   = req_valid && !req_stall;
	assign fin_go    = state_q == sacc_pkg::ST_FINISH && (!rsp_valid_q || !rsp_stall);
	assign cfg_ready = 1'b1;

	// address split with clamped geometry
	logic [4:0]  sb_c, wb_t, wb_c;
	logic [31:0] block, set_idx, base_full;
	always_comb begin
		sb_c = {1'b0, set_bits_q} > LINE_LOG_C ? LINE_LOG_C : {1'b0, set_bits_q};
		wb_t = {2'b0, way_bits_q} > WAY_LOG_C ? WAY_LOG_C : {2'b0, way_bits_q};
		wb_c = wb_t > (LINE_LOG_C - sb_c) ? (LINE_LOG_C - sb_c) : wb_t;
		block     = address >> offset_bits_q;
		set_idx   = block & ((32'd1 << sb_c) - 32'd1);
		base_full = set_idx << wb_c;
	end

	// victim choice after the scan
	logic [15:0]       lfsr_nx;
	logic [31:0]       lfsr_ext;
	logic [LINE_W-1:0] way_mask, rnd_way, victim;
	logic              miss_alloc;
	always_comb begin
		lfsr_nx  = lfsr_q[0] ? ((lfsr_q >> 1) ^ sacc_pkg::LFSR_MASK) : (lfsr_q >> 1);
		lfsr_ext = {16'b0, lfsr_nx};
		way_mask = LINE_W'(len_q - CNT_W'(1));
		rnd_way  = lfsr_ext[LINE_W-1:0] & way_mask;
		if (inv_q) begin
			victim = iw_q;
		end else if (random_replace_q) begin
			victim = rnd_way;
		end else begin
			victim = best_q;
		end
		miss_alloc = !found_q && (cmd_q != sacc_pkg::CMD_WRITE || write_back_q);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			sacc_pkg::ST_CLEAR: begin
				if (cnt_q == LINES_C - CNT_W'(1)) state_nx = sacc_pkg::ST_IDLE;
			end
			sacc_pkg::ST_IDLE: begin
				if (req_acc) begin
					if (command == sacc_pkg::CMD_READ || command == sacc_pkg::CMD_WRITE) begin
						state_nx = sacc_pkg::ST_SCAN;
					end else if (command == sacc_pkg::CMD_FLUSH && write_back_q) begin
						state_nx = sacc_pkg::ST_FLUSH;
					end else begin
						state_nx = sacc_pkg::ST_FINISH;
					end
				end
			end
			sacc_pkg::ST_SCAN: begin
				if (sweep_done) begin
					state_nx = (found_q || miss_alloc) ? sacc_pkg::ST_TREAD : sacc_pkg::ST_FINISH;
				end
			end
			sacc_pkg::ST_TREAD:  state_nx = sacc_pkg::ST_TWAIT;
			sacc_pkg::ST_TWAIT:  state_nx = sacc_pkg::ST_UPDATE;
			sacc_pkg::ST_UPDATE: if (sweep_done) state_nx = sacc_pkg::ST_FINISH;
			sacc_pkg::ST_FLUSH:  if (sweep_done) state_nx = sacc_pkg::ST_FINISH;
			sacc_pkg::ST_FINISH: if (fin_go) state_nx = sacc_pkg::ST_IDLE;
			default: state_nx = sacc_pkg::ST_IDLE;
		endcase
	end

	// ram port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = base_q + rj_s1;
		ram_wdata = rd;
		ram_raddr = base_q + cnt_q[LINE_W-1:0];
		unique case (state_q)
			sacc_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q[LINE_W-1:0];
				ram_wdata = '0;
			end
			sacc_pkg::ST_TREAD: ram_raddr = base_q + tw_q;
			sacc_pkg::ST_UPDATE: begin
				ram_we = rv_s1;
				if (rj_s1 == tw_q) begin
					ram_wdata.valid = 1'b1;
					ram_wdata.rank  = '0;
					if (alloc_q) begin
						ram_wdata.tag   = tag_q;
						ram_wdata.dirty = cmd_q == sacc_pkg::CMD_WRITE;
					end else begin
						ram_wdata.dirty = rd.dirty ||
						                  (cmd_q == sacc_pkg::CMD_WRITE && write_back_q);
					end
				end else if (rd.valid && (!old_valid_q || rd.rank < old_rank_q) &&
				             rd.rank != sacc_pkg::RANK_MAX) begin
					ram_wdata.rank = rd.rank + 4'd1;
				end
			end
			sacc_pkg::ST_FLUSH: begin
				// clean only valid dirty lines
				ram_we          = rv_s1 && rd.valid && rd.dirty;
				ram_wdata.dirty = 1'b0;
			end
			default: ;
		endcase
	end

	function automatic logic [COUNTER_BITS-1:0] sat_add(
		input logic [COUNTER_BITS-1:0] c,
		input logic [CNT_W-1:0]        n
	);
		logic [SW-1:0] s;
		s = SW'(c) + SW'(n);
		sat_add = (s > SW'(CMAX)) ? CMAX : s[COUNTER_BITS-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= sacc_pkg::ST_CLEAR;
			write_back_q     <= 1'b0;
			random_replace_q <= 1'b0;
			offset_bits_q    <= 4'd2;
			set_bits_q       <= 4'd8;
			way_bits_q       <= 3'd2;
			lfsr_q           <= sacc_pkg::SEED_DEFAULT;
			cnt_q            <= '0;
			len_q            <= '0;
			rv_s1            <= 1'b0;
			rsp_valid_q      <= 1'b0;
			for (int i = 0; i < 6; i++) ctr_q[i] <= '0;
		end else begin
			state_q <= state_nx;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					sacc_pkg::CFG_WRITE_BACK:     write_back_q <= cfg_data[0];
					sacc_pkg::CFG_RANDOM_REPLACE: random_replace_q <= cfg_data[0];
					sacc_pkg::CFG_OFFSET_BITS:    offset_bits_q <= cfg_data[3:0];
					sacc_pkg::CFG_SET_BITS:       set_bits_q <= cfg_data[3:0];
					sacc_pkg::CFG_WAY_BITS:       way_bits_q <= cfg_data[2:0];
					sacc_pkg::CFG_RANDOM_SEED: begin
						// zero seed would lock the lfsr
						lfsr_q <= (cfg_data != 16'd0) ? cfg_data : sacc_pkg::SEED_DEFAULT;
					end
					default: ;
				endcase
			end

			rv_s1 <= sweep_st && issue;
			if (state_q == sacc_pkg::ST_CLEAR || (sweep_st && issue)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end

			if (req_acc) begin
				cnt_q <= '0;
				if (command == sacc_pkg::CMD_FLUSH) begin
					len_q <= LINES_C;
				end else begin
					len_q <= CNT_W'(1) << wb_c;
				end
			end
			if (state_q == sacc_pkg::ST_SCAN && sweep_done && !found_q && miss_alloc &&
			    !inv_q && random_replace_q) begin
				lfsr_q <= lfsr_nx;
			end
			if (state_q == sacc_pkg::ST_TWAIT) cnt_q <= '0;

			// a new result may replace one leaving in the same cycle
			if (fin_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (fin_go) begin
				ctr_q[0] <= sat_add(ctr_q[0], CNT_W'(cmd_q == sacc_pkg::CMD_READ));
				ctr_q[1] <= sat_add(ctr_q[1], CNT_W'(cmd_q == sacc_pkg::CMD_WRITE));
				ctr_q[2] <= sat_add(ctr_q[2], CNT_W'(found_q && cmd_q == sacc_pkg::CMD_READ));
				ctr_q[3] <= sat_add(ctr_q[3], CNT_W'(found_q && cmd_q == sacc_pkg::CMD_WRITE));
				ctr_q[4] <= sat_add(ctr_q[4], CNT_W'(fetch_q));
				ctr_q[5] <= sat_add(ctr_q[5], mw_q);
			end
		end
	end

	// payload registers
	logic [CNT_W+10:0] mw_ext;
	assign mw_ext = {11'b0, mw_q};

	always_ff @(posedge clk) begin
		if (req_acc) begin
			cmd_q   <= sacc_pkg::cmd_t'(command);
			tag_q   <= block >> sb_c;
			base_q  <= (command == sacc_pkg::CMD_FLUSH) ? '0 : base_full[LINE_W-1:0];
			found_q <= 1'b0;
			inv_q   <= 1'b0;
			alloc_q <= 1'b0;
			fetch_q <= 1'b0;
			mw_q    <= '0;
		end
		rj_s1 <= cnt_q[LINE_W-1:0];

		// tag scan, one way per cycle
		if (state_q == sacc_pkg::ST_SCAN && rv_s1) begin
			if (!found_q && rd.valid && rd.tag == tag_q) begin
				found_q <= 1'b1;
				hw_q    <= rj_s1;
			end
			if (!inv_q && !rd.valid) begin
				inv_q <= 1'b1;
				iw_q  <= rj_s1;
			end
			if (rj_s1 == '0 || rd.rank > best_rank_q) begin
				best_q      <= rj_s1;
				best_rank_q <= rd.rank;
			end
		end

		// target way decision
		if (state_q == sacc_pkg::ST_SCAN && sweep_done) begin
			if (found_q) begin
				tw_q <= hw_q;
				mw_q <= CNT_W'(cmd_q == sacc_pkg::CMD_WRITE && !write_back_q);
			end else if (miss_alloc) begin
				tw_q    <= victim;
				alloc_q <= 1'b1;
				fetch_q <= 1'b1;
			end else begin
				mw_q <= CNT_W'(1);
			end
		end

		// old state of the target way
		if (state_q == sacc_pkg::ST_TWAIT) begin
			old_valid_q <= rd.valid;
			old_rank_q  <= rd.rank;
			if (alloc_q && write_back_q && rd.valid && rd.dirty) mw_q <= CNT_W'(1);
		end

		if (state_q == sacc_pkg::ST_FLUSH && rv_s1 && rd.valid && rd.dirty) begin
			mw_q <= mw_q + CNT_W'(1);
		end

		if (fin_go) begin
			hit_q     <= found_q;
			fetched_q <= fetch_q;
			mwr_q     <= mw_ext[10:0];
		end
	end

	// outputs show the low bits of the counters
	logic [COUNTER_BITS+47:0] c_ext [6];
	always_comb begin
		for (int i = 0; i < 6; i++) c_ext[i] = {48'b0, ctr_q[i]};
	end

	assign rsp_valid           = rsp_valid_q;
	assign hit                 = hit_q;
	assign line_fetched        = fetched_q;
	assign memory_writes       = mwr_q;
	assign total_reads         = c_ext[0][47:0];
	assign total_writes        = c_ext[1][47:0];
	assign read_hits           = c_ext[2][47:0];
	assign write_hits          = c_ext[3][47:0];
	assign memory_reads_total  = c_ext[4][47:0];
	assign memory_writes_total = c_ext[5][47:0];

	// a hit never also fetches a line
	`SACC_ASSERT_NEVER(a_hit_no_fetch, rsp_valid_q && hit_q && fetched_q, "hit with line fetch")
	// sweeps write only entries whose read data has come back
	`SACC_ASSERT_NEVER(a_we_needs_data,
		ram_we && state_q != sacc_pkg::ST_CLEAR && !rv_s1, "ram write without read data")
	// the sweep counter never passes its length
	`SACC_ASSERT_NEVER(a_cnt_range, sweep_st && cnt_q > len_q, "sweep counter overrun")
	// a finished item always leaves a result behind
	`SACC_ASSERT_NEXT(a_finish_result, fin_go, rsp_valid_q, "result lost at finish")

endmodule

// File: dv/tb.sv
// self-checking testbench for set_assoc_cache_controller_unit
// predicts hit, fetch, memory writes and running counters per command
// depends on sacc_pkg and the rtl of the cache controller
module tb;

	localparam int NLINES = 1024;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [63:0] CNT_MAX = 64'hFFFF_FFFF_FFFF;

	// counter slots, in output order
	localparam int K_READS = 0;
	localparam int K_WRITES = 1;
	localparam int K_RHITS = 2;
	localparam int K_WHITS = 3;
	localparam int K_MREADS = 4;
	localparam int K_MWRITES = 5;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [1:0]  command;
	logic [31:0] address;
	logic        rsp_valid;
	logic        rsp_stall;
	logic        hit;
	logic        line_fetched;
	logic [10:0] memory_writes;
	logic [47:0] total_reads;
	logic [47:0] total_writes;
	logic [47:0] read_hits;
	logic [47:0] write_hits;
	logic [47:0] memory_reads_total;
	logic [47:0] memory_writes_total;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	set_assoc_cache_controller_unit uut (.*);

	// expected result of one command: hit, fetched, writes, six counters
	typedef struct {
		logic [63:0] f [9];
	} cache_result_t;

	cache_result_t result_q [$];

	// shadow of the configuration registers
	logic        wb_mode;
	logic        rnd_mode;
	logic [3:0]  off_bits;
	logic [3:0]  set_bits_r;
	logic [2:0]  way_bits_r;

	// shadow of the tag store
	logic        sh_valid [NLINES];
	logic        sh_dirty [NLINES];
	logic [31:0] sh_tag [NLINES];
	logic [3:0]  sh_rank [NLINES];
	logic [15:0] sh_lfsr;
	logic [63:0] sh_cnt [6];

	int fails;
	int send_idle_pct;
	int rcv_idle_pct;
	int hold_cycles;
	int quiet_cycles;

	string field_names [9] = '{"hit", "line_fetched", "memory_writes", "total_reads",
		"total_writes", "read_hits", "write_hits", "memory_reads_total",
		"memory_writes_total"};

	// clock and one reset at the start
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// clamped geometry as the block applies it
	function automatic int eff_sets_log();
		return (set_bits_r > 10) ? 10 : int'(set_bits_r);
	endfunction

	function automatic int eff_ways_log();
		int wl;
		wl = (way_bits_r > 4) ? 4 : int'(way_bits_r);
		if (wl > 10 - eff_sets_log())
			wl = 10 - eff_sets_log();
		return wl;
	endfunction

	function automatic void bump(int k, logic [63:0] n);
		if (n > CNT_MAX - sh_cnt[k])
			sh_cnt[k] = CNT_MAX;
		else
			sh_cnt[k] = sh_cnt[k] + n;
	endfunction

	// make way w the most recently used of its set
	function automatic void promote_way(int base, int ways, int w);
		logic       was;
		logic [3:0] old;
		int         k;
		was = sh_valid[base + w];
		old = sh_rank[base + w];
		for (int i = 0; i < ways; i++) begin
			k = base + i;
			if (i == w || !sh_valid[k])
				continue;
			if ((!was || sh_rank[k] < old) && sh_rank[k] < sacc_pkg::RANK_MAX)
				sh_rank[k] = sh_rank[k] + 4'd1;
		end
		sh_rank[base + w] = 4'd0;
	endfunction

	function automatic int choose_victim(int base, int ways);
		int best;
		logic low;
		best = 0;
		for (int i = 0; i < ways; i++)
			if (!sh_valid[base + i])
				return i;
		if (rnd_mode) begin
			low = sh_lfsr[0];
			sh_lfsr = sh_lfsr >> 1;
			if (low)
				sh_lfsr = sh_lfsr ^ sacc_pkg::LFSR_MASK;
			return int'(sh_lfsr) & (ways - 1);
		end
		for (int i = 1; i < ways; i++)
			if (sh_rank[base + i] > sh_rank[base + best])
				best = i;
		return best;
	endfunction

	// apply one command to the shadow cache and return what the block should report
	function automatic cache_result_t cache_access(sacc_pkg::cmd_t c, logic [31:0] a);
		cache_result_t r;
		int sl, wl, ways, set_i, base, w, v, k;
		logic [31:0] blk, tg;
		logic is_wr, h, fet;
		logic [10:0] mw;
		h = 1'b0;
		fet = 1'b0;
		mw = '0;
		sl = eff_sets_log();
		wl = eff_ways_log();
		if (c == sacc_pkg::CMD_READ || c == sacc_pkg::CMD_WRITE) begin
			ways = 1 << wl;
			blk = a >> off_bits;
			set_i = int'(blk & ((32'd1 << sl) - 32'd1));
			tg = blk >> sl;
			base = set_i << wl;
			w = ways;
			is_wr = (c == sacc_pkg::CMD_WRITE);
			for (int i = 0; i < ways; i++)
				if (sh_valid[base + i] && sh_tag[base + i] == tg) begin
					w = i;
					break;
				end
			bump(is_wr ? K_WRITES : K_READS, 1);
			if (w < ways) begin
				h = 1'b1;
				promote_way(base, ways, w);
				if (!is_wr)
					bump(K_RHITS, 1);
				else begin
					bump(K_WHITS, 1);
					if (wb_mode)
						sh_dirty[base + w] = 1'b1;
					else
						mw = 11'd1;
				end
			end else if (!is_wr || wb_mode) begin
				v = choose_victim(base, ways);
				k = base + v;
				fet = 1'b1;
				// write-through drops a dirty victim silently
				if (wb_mode && sh_valid[k] && sh_dirty[k])
					mw = 11'd1;
				promote_way(base, ways, v);
				sh_valid[k] = 1'b1;
				sh_tag[k] = tg;
				sh_dirty[k] = is_wr;
			end else begin
				mw = 11'd1;
			end
		end else if (c == sacc_pkg::CMD_FLUSH && wb_mode) begin
			for (int i = 0; i < NLINES; i++)
				if (sh_valid[i] && sh_dirty[i]) begin
					mw = mw + 11'd1;
					sh_dirty[i] = 1'b0;
				end
		end
		if (fet)
			bump(K_MREADS, 1);
		bump(K_MWRITES, 64'(mw));
		r.f[0] = 64'(h);
		r.f[1] = 64'(fet);
		r.f[2] = 64'(mw);
		for (int i = 0; i < 6; i++)
			r.f[3 + i] = sh_cnt[i] & CNT_MAX;
		return r;
	endfunction

	// drive one command and record its prediction once accepted
	task automatic send_cmd(sacc_pkg::cmd_t c, logic [31:0] a);
		cache_result_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		command <= c;
		address <= a;
		do @(posedge clk); while (!(req_valid && !req_stall));
		r = cache_access(c, a);
		result_q.push_back(r);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	// register writes are to be made only while the block is idle; the block itself does not enforce this
	task automatic drain();
		stop_sending();
		while (result_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(sacc_pkg::cfg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			sacc_pkg::CFG_WRITE_BACK:     wb_mode = val[0];
			sacc_pkg::CFG_RANDOM_REPLACE: rnd_mode = val[0];
			sacc_pkg::CFG_OFFSET_BITS:    off_bits = val[3:0];
			sacc_pkg::CFG_SET_BITS:       set_bits_r = val[3:0];
			sacc_pkg::CFG_WAY_BITS:       way_bits_r = val[2:0];
			sacc_pkg::CFG_RANDOM_SEED:
				sh_lfsr = (val == 16'd0) ? sacc_pkg::SEED_DEFAULT : val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_geometry(logic wb, logic rnd, logic [3:0] ob, logic [3:0] sb,
		logic [2:0] wbits);
		write_reg(sacc_pkg::CFG_WRITE_BACK, 16'(wb));
		write_reg(sacc_pkg::CFG_RANDOM_REPLACE, 16'(rnd));
		write_reg(sacc_pkg::CFG_OFFSET_BITS, 16'(ob));
		write_reg(sacc_pkg::CFG_SET_BITS, 16'(sb));
		write_reg(sacc_pkg::CFG_WAY_BITS, 16'(wbits));
	endtask

	// address in one of a few sets with a tag from a small pool, so sets overflow
	function automatic logic [31:0] pool_addr();
		int sl, wl;
		logic [63:0] t, s, lo;
		sl = eff_sets_log();
		wl = eff_ways_log();
		t = 64'($urandom_range(2 * (1 << wl) + 1));
		s = 64'($urandom_range(((1 << sl) > 4) ? 3 : (1 << sl) - 1));
		lo = 64'($urandom) & ((64'd1 << off_bits) - 64'd1);
		return 32'((t << (off_bits + sl)) | (s << off_bits) | lo);
	endfunction

	// extremes of the fields, every command and the named corner cases
	task automatic test_directed();
		// write-through defaults after reset
		send_cmd(sacc_pkg::CMD_READ, 32'h0000_0000);
		send_cmd(sacc_pkg::CMD_READ, 32'hFFFF_FFFF);
		send_cmd(sacc_pkg::CMD_READ, 32'h0000_0003);
		send_cmd(sacc_pkg::CMD_WRITE, 32'h0000_0001);
		send_cmd(sacc_pkg::CMD_WRITE, 32'h1234_5678);
		send_cmd(sacc_pkg::CMD_NOP, 32'hFFFF_FFFF);
		send_cmd(sacc_pkg::CMD_FLUSH, 32'h0);
		drain();
		// write-back, one set of four ways overflowed with dirty lines
		write_reg(sacc_pkg::CFG_WRITE_BACK, 16'd1);
		for (int i = 0; i < 6; i++)
			send_cmd(sacc_pkg::CMD_WRITE, 32'(i) << 10);
		send_cmd(sacc_pkg::CMD_WRITE, 32'h0000_0400);
		send_cmd(sacc_pkg::CMD_READ, 32'h0000_0000);
		send_cmd(sacc_pkg::CMD_FLUSH, 32'hFFFF_FFFF);
		drain();
		// a miss after switching to write-through evicts a line that the flush left clean
		write_reg(sacc_pkg::CFG_WRITE_BACK, 16'd0);
		send_cmd(sacc_pkg::CMD_READ, 32'h0000_1800);
		drain();
		// zero seed falls back to the default, then random victims
		write_reg(sacc_pkg::CFG_RANDOM_SEED, 16'd0);
		write_reg(sacc_pkg::CFG_RANDOM_REPLACE, 16'd1);
		for (int i = 0; i < 3; i++)
			send_cmd(sacc_pkg::CMD_READ, 32'(i + 8) << 10);
		drain();
		write_reg(sacc_pkg::CFG_RANDOM_SEED, 16'hFFFF);
		// oversized geometry is clamped
		set_geometry(1'b1, 1'b0, 4'd12, 4'd15, 3'd7);
		send_cmd(sacc_pkg::CMD_WRITE, 32'hFFFF_F000);
		send_cmd(sacc_pkg::CMD_READ, 32'hFFFF_FFFF);
		drain();
		// one set with one way
		set_geometry(1'b1, 1'b0, 4'd0, 4'd0, 3'd0);
		send_cmd(sacc_pkg::CMD_WRITE, 32'h0000_0001);
		send_cmd(sacc_pkg::CMD_READ, 32'h0000_0002);
		send_cmd(sacc_pkg::CMD_FLUSH, 32'h0);
		drain();
	endtask

	// random register setting followed by a stretch of random commands
	task automatic test_random(int n_items, int s_idle, int r_idle);
		int pick;
		send_idle_pct = s_idle;
		rcv_idle_pct = r_idle;
		for (int p = 0; p < n_items / 40; p++) begin
			drain();
			set_geometry(1'($urandom), 1'($urandom),
				($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(6)),
				4'($urandom), 3'($urandom));
			write_reg(sacc_pkg::CFG_RANDOM_SEED, 16'($urandom));
			for (int i = 0; i < 40; i++) begin
				pick = $urandom_range(99);
				if (pick < 80)
					send_cmd(pick[0] ? sacc_pkg::CMD_WRITE : sacc_pkg::CMD_READ, pool_addr());
				else if (pick < 92)
					send_cmd(pick[0] ? sacc_pkg::CMD_WRITE : sacc_pkg::CMD_READ, $urandom);
				else if (pick < 98)
					send_cmd(sacc_pkg::CMD_NOP, $urandom);
				else
					send_cmd(sacc_pkg::CMD_FLUSH, $urandom);
			end
		end
		drain();
	endtask

	// receiver holds off while commands keep coming, so the input backs up
	task automatic test_backpressure();
		send_idle_pct = 0;
		rcv_idle_pct = 0;
		set_geometry(1'b1, 1'b0, 4'd2, 4'd2, 3'd1);
		@(posedge clk);
		hold_cycles = 300;
		for (int i = 0; i < 12; i++)
			send_cmd(i[0] ? sacc_pkg::CMD_WRITE : sacc_pkg::CMD_READ, pool_addr());
		drain();
	endtask

	// receiver stall, either random or a long hold
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			rsp_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// check every accepted result against the oldest prediction
	always @(posedge clk) begin
		cache_result_t want;
		logic [63:0] got [9];
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (result_q.size() == 0) begin
				$display("%0t: result with nothing expected", $time);
				fails++;
			end else begin
				want = result_q.pop_front();
				got = '{64'(hit), 64'(line_fetched), 64'(memory_writes), 64'(total_reads),
					64'(total_writes), 64'(read_hits), 64'(write_hits),
					64'(memory_reads_total), 64'(memory_writes_total)};
				for (int i = 0; i < 9; i++)
					if (got[i] !== want.f[i]) begin
						$display("%0t: %s expected %0d got %0d", $time, field_names[i],
							want.f[i], got[i]);
						fails++;
					end
			end
		end
	end

	// watchdog on cycles with no handshake on any channel
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		command = sacc_pkg::CMD_NOP;
		address = '0;
		cfg_valid = 1'b0;
		cfg_index = sacc_pkg::CFG_WRITE_BACK;
		cfg_data = '0;
		rsp_stall = 1'b0;
		hold_cycles = 0;
		quiet_cycles = 0;
		fails = 0;
		send_idle_pct = 0;
		rcv_idle_pct = 0;
		// shadow reset state
		wb_mode = 1'b0;
		rnd_mode = 1'b0;
		off_bits = 4'd2;
		set_bits_r = 4'd8;
		way_bits_r = 3'd2;
		sh_lfsr = sacc_pkg::SEED_DEFAULT;
		for (int i = 0; i < NLINES; i++) begin
			sh_valid[i] = 1'b0;
			sh_dirty[i] = 1'b0;
			sh_tag[i] = '0;
			sh_rank[i] = '0;
		end
		for (int i = 0; i < 6; i++)
			sh_cnt[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random(360, 10, 85);
		test_random(360, 85, 10);
		test_random(400, 0, 0);
		test_backpressure();

		// let any late result surface
		repeat (50) @(posedge clk);
		if (fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
